// File: rtl/dfs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// dfs_pkg: shared types and constants of the directional focus search
// Table geometry, operation and direction codes, and the records that pass
// between the sequencer and the scoring unit.
// ============================================================================
package dfs_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int COORD_BITS  = 12;

  localparam int IDX_BITS   = $clog2(MAX_ENTRIES);
  localparam int CNT_BITS   = $clog2(MAX_ENTRIES + 1);
  // Doubled center 2*x + w is at most three times the largest coordinate.
  localparam int CTR_W      = COORD_BITS + 2;
  localparam int DELTA_W    = CTR_W + 1;
  // Score |axis| + 2*|cross| is at most nine times the largest coordinate.
  localparam int SCORE_W    = COORD_BITS + 4;
  localparam int FOCUS_W    = 6;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_FOCUS = 2'd2;
  localparam logic [1:0] OP_MOVE  = 2'd3;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam logic signed [DELTA_W-1:0] DELTA_POS2 = DELTA_W'(2);
  localparam logic signed [DELTA_W-1:0] DELTA_NEG2 = -DELTA_POS2;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } rect_t;

  // One table entry on its way into the scoring unit.
  typedef struct packed {
    logic                vld;
    logic [IDX_BITS-1:0] idx;
    rect_t               rect;
  } probe_t;

  // One qualifying candidate leaving the scoring unit.
  typedef struct packed {
    logic                vld;
    logic [IDX_BITS-1:0] idx;
    logic [SCORE_W-1:0]  score;
  } cand_t;

  function automatic logic [CTR_W-1:0] center2(input logic [COORD_BITS-1:0] pos,
                                               input logic [COORD_BITS-1:0] size);
    center2 = CTR_W'({pos, 1'b0}) + CTR_W'(size);
  endfunction

endpackage

// File: rtl/dfs_score_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// dfs_score_unit: two-stage scoring of one table entry per cycle
// Takes a stored rectangle, forms its doubled-center offset from the current
// focus, checks that it lies beyond in the asked direction and scores it.
// ============================================================================
module dfs_score_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  dfs_pkg::probe_t             probe,
  input  logic [dfs_pkg::CTR_W-1:0]   cur_cx,
  input  logic [dfs_pkg::CTR_W-1:0]   cur_cy,
  input  logic [1:0]                  dir,
  output dfs_pkg::cand_t              cand
);

  logic                             a_vld;
  logic [dfs_pkg::IDX_BITS-1:0]     a_idx;
  logic signed [dfs_pkg::DELTA_W-1:0] a_dx;
  logic signed [dfs_pkg::DELTA_W-1:0] a_dy;

  logic signed [dfs_pkg::DELTA_W-1:0] dx_next;
  logic signed [dfs_pkg::DELTA_W-1:0] dy_next;
  logic signed [dfs_pkg::DELTA_W-1:0] neg_dx;
  logic signed [dfs_pkg::DELTA_W-1:0] neg_dy;
  logic [dfs_pkg::CTR_W-1:0]          abs_dx;
  logic [dfs_pkg::CTR_W-1:0]          abs_dy;
  logic [dfs_pkg::CTR_W-1:0]          axis;
  logic [dfs_pkg::CTR_W-1:0]          cross_mag;
  logic                               qual;
  logic [dfs_pkg::SCORE_W-1:0]        score_next;

  // Stage A: offsets of the doubled centers.
  always_comb begin
    dx_next = $signed({1'b0, dfs_pkg::center2(probe.rect.x, probe.rect.w)})
            - $signed({1'b0, cur_cx});
    dy_next = $signed({1'b0, dfs_pkg::center2(probe.rect.y, probe.rect.h)})
            - $signed({1'b0, cur_cy});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= probe.vld;
    end
    a_idx <= probe.idx;
    a_dx  <= dx_next;
    a_dy  <= dy_next;
  end

  // Stage B: direction test, magnitudes and weighted sum.
  always_comb begin
    neg_dx = -a_dx;
    neg_dy = -a_dy;
    abs_dx = a_dx[dfs_pkg::DELTA_W-1] ? neg_dx[dfs_pkg::CTR_W-1:0]
                                      : a_dx[dfs_pkg::CTR_W-1:0];
    abs_dy = a_dy[dfs_pkg::DELTA_W-1] ? neg_dy[dfs_pkg::CTR_W-1:0]
                                      : a_dy[dfs_pkg::CTR_W-1:0];
    case (dir)
      dfs_pkg::DIR_LEFT:  qual = a_dx < dfs_pkg::DELTA_NEG2;
      dfs_pkg::DIR_RIGHT: qual = a_dx > dfs_pkg::DELTA_POS2;
      dfs_pkg::DIR_UP:    qual = a_dy < dfs_pkg::DELTA_NEG2;
      default:            qual = a_dy > dfs_pkg::DELTA_POS2;
    endcase
    if (dir == dfs_pkg::DIR_LEFT || dir == dfs_pkg::DIR_RIGHT) begin
      axis      = abs_dx;
      cross_mag = abs_dy;
    end else begin
      axis      = abs_dy;
      cross_mag = abs_dx;
    end
    score_next = dfs_pkg::SCORE_W'(axis) + dfs_pkg::SCORE_W'({cross_mag, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand.vld <= 1'b0;
    end else begin
      cand.vld <= a_vld && qual;
    end
    cand.idx   <= a_idx;
    cand.score <= score_next;
  end

endmodule

// File: rtl/directional_focus_search.sv
`timescale 1ns / 1ps
// ============================================================================
// directional_focus_search: focus table with directional navigation
// Stores rectangles, tracks one focused entry and moves the focus to the
// nearest entry in a requested direction.
// ============================================================================
// Usage
//   A request enters on in_valid/in_ready with an opcode (clear, add, set
//   focus, move) and its operands. Every request produces exactly one
//   response on out_valid/out_ready carrying done_res, focus_index and
//   focus_valid as they stand after the request.
//   Clear, add and set focus pass from acceptance through the push state
//   to the response register. A move with a valid focus reads the focused
//   entry, then streams every stored entry through the scoring unit, one per
//   cycle from the single table read port, and drains the pipeline before
//   the push. A move without focus goes straight to the push state.
//   in_ready is high only while the sequencer is idle; one request is in
//   work at a time.
//   The response sits in an output register. A new request is accepted while
//   an earlier response still waits there; the new response is held back
//   until the receiver has taken the old one.
//   Reset empties the table and drops the focus at once; no clearing pass
//   is needed because only entries below the fill count are ever read.
// ============================================================================
module directional_focus_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [11:0] rect_x,
  input  logic [11:0] rect_y,
  input  logic [11:0] rect_w,
  input  logic [11:0] rect_h,
  input  logic [5:0]  target_index,
  input  logic [1:0]  direction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        done_res,
  output logic [5:0]  focus_index,
  output logic        focus_valid
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CUR   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_PUSH  = 3'd5;

  // Pipeline depth behind the last table read: read data, stage A, stage B.
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  logic [2:0]                        state;
  logic [dfs_pkg::CNT_BITS-1:0]      entry_count;
  logic [dfs_pkg::IDX_BITS-1:0]      focused_entry;
  logic                              focus_present;
  logic [dfs_pkg::CNT_BITS-1:0]      scan_i;
  logic [1:0]                        drain_cnt;
  logic [1:0]                        dir_q;
  logic [dfs_pkg::CTR_W-1:0]         cx_q;
  logic [dfs_pkg::CTR_W-1:0]         cy_q;
  logic                              res_done;
  logic                              best_have;
  logic [dfs_pkg::IDX_BITS-1:0]      best_idx;
  logic [dfs_pkg::SCORE_W-1:0]       best_score;

  dfs_pkg::rect_t                    rect_table [dfs_pkg::MAX_ENTRIES];
  dfs_pkg::rect_t                    rd_data;
  dfs_pkg::rect_t                    wr_rect;
  logic [dfs_pkg::IDX_BITS-1:0]      rd_addr;
  logic                              p0_vld;
  logic [dfs_pkg::IDX_BITS-1:0]      p0_idx;
  dfs_pkg::probe_t                   probe;
  dfs_pkg::cand_t                    cand;

  logic accept;
  logic table_full;
  logic do_write;
  logic push_ok;

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign table_full = !(entry_count < dfs_pkg::CNT_BITS'(dfs_pkg::MAX_ENTRIES));
  assign do_write   = accept && (opcode == dfs_pkg::OP_ADD) && !table_full;
  assign push_ok    = !out_valid || out_ready;

  assign wr_rect.x = rect_x[dfs_pkg::COORD_BITS-1:0];
  assign wr_rect.y = rect_y[dfs_pkg::COORD_BITS-1:0];
  assign wr_rect.w = rect_w[dfs_pkg::COORD_BITS-1:0];
  assign wr_rect.h = rect_h[dfs_pkg::COORD_BITS-1:0];

  // While idle the port keeps reading the focused entry, so its rectangle is
  // ready in the cycle after a move is accepted.
  assign rd_addr = (state == ST_SCAN) ? scan_i[dfs_pkg::IDX_BITS-1:0] : focused_entry;

  always_ff @(posedge clk) begin
    if (do_write) begin
      rect_table[entry_count[dfs_pkg::IDX_BITS-1:0]] <= wr_rect;
    end
    rd_data <= rect_table[rd_addr];
  end

  // Issue tag that travels alongside the read data. The focused entry itself
  // is never a candidate.
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_vld <= 1'b0;
    end else begin
      p0_vld <= (state == ST_SCAN) && (scan_i[dfs_pkg::IDX_BITS-1:0] != focused_entry);
    end
    p0_idx <= scan_i[dfs_pkg::IDX_BITS-1:0];
  end

  assign probe.vld  = p0_vld;
  assign probe.idx  = p0_idx;
  assign probe.rect = rd_data;

  dfs_score_unit u_score (
    .clk    (clk),
    .rst    (rst),
    .probe  (probe),
    .cur_cx (cx_q),
    .cur_cy (cy_q),
    .dir    (dir_q),
    .cand   (cand)
  );

  // Running minimum. Candidates arrive in index order, and only a strictly
  // smaller score replaces the best, so the earliest minimum wins.
  always_ff @(posedge clk) begin
    if (state == ST_CUR) begin
      best_have <= 1'b0;
    end else if (cand.vld && (!best_have || cand.score < best_score)) begin
      best_have  <= 1'b1;
      best_idx   <= cand.idx;
      best_score <= cand.score;
    end
  end

  // Sequencer and focus state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      entry_count   <= '0;
      focused_entry <= '0;
      focus_present <= 1'b0;
      scan_i        <= '0;
      drain_cnt     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            dir_q <= direction;
            case (opcode)
              dfs_pkg::OP_CLEAR: begin
                entry_count   <= '0;
                focused_entry <= '0;
                focus_present <= 1'b0;
                res_done      <= 1'b0;
                state         <= ST_PUSH;
              end
              dfs_pkg::OP_ADD: begin
                res_done <= !table_full;
                state    <= ST_PUSH;
                if (!table_full) begin
                  if (!focus_present) begin
                    focused_entry <= entry_count[dfs_pkg::IDX_BITS-1:0];
                    focus_present <= 1'b1;
                  end
                  entry_count <= entry_count + 1'b1;
                end
              end
              dfs_pkg::OP_FOCUS: begin
                state <= ST_PUSH;
                if (32'(target_index) < 32'(entry_count)) begin
                  focused_entry <= dfs_pkg::IDX_BITS'(target_index);
                  focus_present <= 1'b1;
                  res_done      <= 1'b1;
                end else begin
                  res_done <= 1'b0;
                end
              end
              default: begin
                if (!focus_present
                    || dfs_pkg::CNT_BITS'(focused_entry) >= entry_count) begin
                  state <= ST_PUSH;
                  if (entry_count != '0) begin
                    focused_entry <= '0;
                    focus_present <= 1'b1;
                    res_done      <= 1'b1;
                  end else begin
                    res_done <= 1'b0;
                  end
                end else begin
                  res_done <= 1'b0;
                  state    <= ST_CUR;
                end
              end
            endcase
          end
        end
        ST_CUR: begin
          // rd_data holds the focused rectangle here.
          cx_q   <= dfs_pkg::center2(rd_data.x, rd_data.w);
          cy_q   <= dfs_pkg::center2(rd_data.y, rd_data.h);
          scan_i <= '0;
          state  <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_i == entry_count - 1'b1) begin
            drain_cnt <= '0;
            state     <= ST_DRAIN;
          end else begin
            scan_i <= scan_i + 1'b1;
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt + 1'b1;
          if (drain_cnt == DRAIN_LAST) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (best_have) begin
            focused_entry <= best_idx;
            res_done      <= 1'b1;
          end
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (push_ok) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_PUSH && push_ok) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (state == ST_PUSH && push_ok) begin
      done_res    <= res_done;
      focus_index <= focus_present ? dfs_pkg::FOCUS_W'(focused_entry) : '0;
      focus_valid <= focus_present;
    end
  end

  // A focused entry always lies inside the filled part of the table.
  a_focus_in_table: assert property (@(posedge clk) disable iff (rst)
    focus_present |-> dfs_pkg::CNT_BITS'(focused_entry) < entry_count)
    else $error("focused entry beyond the fill count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= dfs_pkg::CNT_BITS'(dfs_pkg::MAX_ENTRIES))
    else $error("fill count exceeds table depth");

  // During a search the best candidate is never the entry we move away from.
  a_best_not_self: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN || state == ST_DRAIN || state == ST_FIN) && best_have)
      |-> best_idx != focused_entry)
    else $error("search picked the focused entry");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second request taken while one is in work");

  // Scanning never runs past the filled part of the table.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> scan_i < entry_count)
    else $error("scan index beyond the fill count");

endmodule
